/* hw/rtl/rle_pkg.sv */
// Shared types and constants for the run-length encoder with literal runs.
// Used by rle_ctrl, rle_datapath and rle_literal_run_encoder; no dependencies.
package rle_pkg;

   localparam int MAX_LITERAL  = 63;
   localparam int MAX_RUN      = 128;
   localparam int LIT_HDR_BASE = 128;

   localparam int BYTE_W    = 8;
   localparam int CNT_W     = 8;
   localparam int LIT_IDX_W = $clog2(MAX_LITERAL);
   localparam int LIT_N_W   = $clog2(MAX_LITERAL + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_RBYTE,
      ST_HDR,
      ST_LIT,
      ST_TERM
   } state_type;

   typedef enum logic [2:0] {
      SEL_COUNT,
      SEL_RBYTE,
      SEL_HDR,
      SEL_LIT,
      SEL_TERM
   } out_sel_type;

   typedef struct packed {
      logic        accept;
      logic        load;
      out_sel_type sel;
      logic        last;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic has_pair;
      logic has_lit;
      logic has_term;
      logic term;
      logic lit_done;
   } dp_sts_type;

endpackage

/* hw/rtl/rle_ctrl.sv */
// Sequencer for the encoder: accepts a transaction and steps through its results.
// Depends on rle_pkg; drives rle_datapath through ctl_cmd_type.
module rle_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  rle_pkg::dp_sts_type  sts,
   output rle_pkg::ctl_cmd_type cmd
);

   rle_pkg::state_type state_ff, state_in;
   logic               accept;

   assign req_tready = (state_ff == rle_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rle_pkg::ST_IDLE: begin
            if (accept) begin
               if (sts.has_pair)      state_in = rle_pkg::ST_COUNT;
               else if (sts.has_lit)  state_in = rle_pkg::ST_HDR;
               else if (sts.has_term) state_in = rle_pkg::ST_TERM;
            end
         end
         rle_pkg::ST_COUNT: begin
            if (sts.out_free) state_in = rle_pkg::ST_RBYTE;
         end
         rle_pkg::ST_RBYTE: begin
            if (sts.out_free) state_in = sts.term ? rle_pkg::ST_TERM : rle_pkg::ST_IDLE;
         end
         rle_pkg::ST_HDR: begin
            if (sts.out_free) state_in = rle_pkg::ST_LIT;
         end
         rle_pkg::ST_LIT: begin
            if (sts.out_free && sts.lit_done) begin
               state_in = sts.term ? rle_pkg::ST_TERM : rle_pkg::ST_IDLE;
            end
         end
         rle_pkg::ST_TERM: begin
            if (sts.out_free) state_in = rle_pkg::ST_IDLE;
         end
         default: begin
            state_in = rle_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.accept = accept;
      cmd.sel    = rle_pkg::SEL_TERM;
      case (state_ff)
         rle_pkg::ST_COUNT: begin
            cmd.load = sts.out_free;
            cmd.sel  = rle_pkg::SEL_COUNT;
         end
         rle_pkg::ST_RBYTE: begin
            cmd.load = sts.out_free;
            cmd.sel  = rle_pkg::SEL_RBYTE;
            cmd.last = !sts.term;
         end
         rle_pkg::ST_HDR: begin
            cmd.load = sts.out_free;
            cmd.sel  = rle_pkg::SEL_HDR;
         end
         rle_pkg::ST_LIT: begin
            cmd.load = sts.out_free;
            cmd.sel  = rle_pkg::SEL_LIT;
            cmd.last = sts.lit_done && !sts.term;
         end
         rle_pkg::ST_TERM: begin
            cmd.load = sts.out_free;
            cmd.sel  = rle_pkg::SEL_TERM;
            cmd.last = 1'b1;
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.load)
      else $error("load issued while accepting");
   a_lit_follows_hdr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rle_pkg::ST_HDR) && sts.out_free |=> (state_ff == rle_pkg::ST_LIT))
      else $error("header not followed by literals");
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      cmd.load && (cmd.sel == rle_pkg::SEL_TERM) |-> cmd.last)
      else $error("terminator not marked last");
`endif

endmodule

/* hw/rtl/rle_datapath.sv */
// Encoder datapath: run/literal state, literal memory and the output register.
// Depends on rle_pkg; controlled by rle_ctrl.
module rle_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  rle_pkg::ctl_cmd_type         cmd,
   output rle_pkg::dp_sts_type          sts,
   input  logic [rle_pkg::BYTE_W-1:0]   req_tdata,
   input  logic                         req_tlast,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [rle_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);

   logic [rle_pkg::BYTE_W-1:0]    lit_mem [rle_pkg::MAX_LITERAL];

   logic [rle_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [rle_pkg::BYTE_W-1:0]    run_byte_ff, run_byte_in;
   logic                          in_repeat_ff, in_repeat_in;
   logic [rle_pkg::BYTE_W-1:0]    last_lit_ff, last_lit_in;

   logic [rle_pkg::CNT_W-1:0]     emit_count_ff;
   logic [rle_pkg::BYTE_W-1:0]    emit_byte_ff;
   logic [rle_pkg::LIT_N_W-1:0]   lit_n_ff;
   logic                          term_ff;
   logic [rle_pkg::LIT_IDX_W-1:0] lit_idx_ff, lit_idx_in;
   logic [rle_pkg::BYTE_W-1:0]    rd_data_ff;

   logic                          out_valid_ff, out_valid_in;
   logic [rle_pkg::BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                          out_term_ff, out_term_in;
   logic                          out_last_ff;

   logic                          plan_pair;
   logic [rle_pkg::LIT_N_W-1:0]   plan_lit_n;
   logic                          wr_en;
   logic [rle_pkg::LIT_IDX_W-1:0] wr_addr;
   logic                          lit_done;

   always_comb begin
      cnt_in       = cnt_ff;
      run_byte_in  = run_byte_ff;
      in_repeat_in = in_repeat_ff;
      last_lit_in  = last_lit_ff;
      plan_pair    = 1'b0;
      plan_lit_n   = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      if (req_tlast) begin
         plan_pair = in_repeat_ff && (cnt_ff != '0);
         if (!in_repeat_ff) plan_lit_n = rle_pkg::LIT_N_W'(cnt_ff);
         cnt_in       = '0;
         run_byte_in  = '0;
         in_repeat_in = 1'b0;
      end else if (in_repeat_ff) begin
         if (req_tdata == run_byte_ff) begin
            if (cnt_ff < rle_pkg::CNT_W'(rle_pkg::MAX_RUN)) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               plan_pair = 1'b1;
               cnt_in    = rle_pkg::CNT_W'(1);
            end
         end else begin
            plan_pair    = 1'b1;
            wr_en        = 1'b1;
            last_lit_in  = req_tdata;
            cnt_in       = rle_pkg::CNT_W'(1);
            in_repeat_in = 1'b0;
         end
      end else if (cnt_ff == '0) begin
         wr_en       = 1'b1;
         last_lit_in = req_tdata;
         cnt_in      = rle_pkg::CNT_W'(1);
      end else if (req_tdata == last_lit_ff) begin
         plan_lit_n   = rle_pkg::LIT_N_W'(cnt_ff - 1'b1);
         run_byte_in  = req_tdata;
         cnt_in       = rle_pkg::CNT_W'(2);
         in_repeat_in = 1'b1;
      end else begin
         wr_en       = 1'b1;
         wr_addr     = cnt_ff[rle_pkg::LIT_IDX_W-1:0];
         last_lit_in = req_tdata;
         if ((cnt_ff + 1'b1) >= rle_pkg::CNT_W'(rle_pkg::MAX_LITERAL)) begin
            plan_lit_n = rle_pkg::LIT_N_W'(cnt_ff + 1'b1);
            cnt_in     = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         run_byte_ff  <= '0;
         in_repeat_ff <= 1'b0;
         term_ff      <= 1'b0;
      end else if (cmd.accept) begin
         cnt_ff       <= cnt_in;
         run_byte_ff  <= run_byte_in;
         in_repeat_ff <= in_repeat_in;
         term_ff      <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_lit_ff   <= last_lit_in;
         emit_count_ff <= cnt_ff;
         emit_byte_ff  <= run_byte_ff;
         lit_n_ff      <= plan_lit_n;
      end
   end

   // literal memory: write on accept, read one ahead of the emit index
   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         lit_mem[wr_addr] <= req_tdata;
      end
      rd_data_ff <= lit_mem[lit_idx_in];
   end

   assign lit_done = (lit_idx_ff == rle_pkg::LIT_IDX_W'(lit_n_ff - 1'b1));

   always_comb begin
      lit_idx_in = lit_idx_ff;
      if (cmd.load && (cmd.sel == rle_pkg::SEL_HDR)) begin
         lit_idx_in = '0;
      end else if (cmd.load && (cmd.sel == rle_pkg::SEL_LIT) && !lit_done) begin
         lit_idx_in = lit_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_idx_ff <= '0;
      end else begin
         lit_idx_ff <= lit_idx_in;
      end
   end

   always_comb begin
      out_term_in = 1'b0;
      case (cmd.sel)
         rle_pkg::SEL_COUNT: out_byte_in = emit_count_ff;
         rle_pkg::SEL_RBYTE: out_byte_in = emit_byte_ff;
         rle_pkg::SEL_HDR: begin
            out_byte_in = rle_pkg::BYTE_W'(rle_pkg::LIT_HDR_BASE)
                        + rle_pkg::BYTE_W'(lit_n_ff);
         end
         rle_pkg::SEL_LIT:   out_byte_in = rd_data_ff;
         rle_pkg::SEL_TERM: begin
            out_byte_in = '0;
            out_term_in = 1'b1;
         end
         default:            out_byte_in = '0;
      endcase
   end

   assign out_valid_in = cmd.load ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_byte_ff <= out_byte_in;
         out_term_ff <= out_term_in;
         out_last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_term_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      sts          = '0;
      sts.out_free = !out_valid_ff || rsp_tready;
      sts.has_pair = plan_pair;
      sts.has_lit  = (plan_lit_n != '0);
      sts.has_term = req_tlast;
      sts.term     = term_ff;
      sts.lit_done = lit_done;
   end

`ifndef SYNTHESIS
   a_run_cap: assert property (@(posedge clock) disable iff (reset)
      in_repeat_ff |-> (cnt_ff != '0) && (cnt_ff <= rle_pkg::CNT_W'(rle_pkg::MAX_RUN)))
      else $error("run count out of range");
   a_lit_cap: assert property (@(posedge clock) disable iff (reset)
      !in_repeat_ff |-> (cnt_ff < rle_pkg::CNT_W'(rle_pkg::MAX_LITERAL)))
      else $error("literal count out of range");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !cmd.load)
      else $error("output register overwritten");
`endif

endmodule

/* hw/rtl/rle_literal_run_encoder.sv */
// Top level of the byte-stream run-length encoder with literal runs.
// Depends on rle_pkg; instantiates rle_ctrl and rle_datapath.
//
// Takes one byte per req transaction (req_tlast marks end of input) and emits
// repeat sequences (count 1..128, byte) and literal sequences (128+n, n bytes,
// n up to 63); end of input flushes what is pending and then sends a
// terminator (rsp_tuser high, data 0). rsp_tlast marks the last result of each
// input transaction. An input that yields no result leaves the sequencer idle;
// otherwise it loads one result per cycle into the output register while that
// register is free (empty or rsp_tready high), and accepts again only once
// the last of them is loaded. The literal memory holds the pending literal
// bytes and is read one entry per loaded result during a flush.
module rle_literal_run_encoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [rle_pkg::BYTE_W-1:0] req_tdata,  // [7:0] data_byte
   input  logic                       req_tlast,  // end_of_input
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [rle_pkg::BYTE_W-1:0] rsp_tdata,  // [7:0] out_byte
   output logic                       rsp_tuser,  // [0] is_terminator
   output logic                       rsp_tlast   // last
);

   rle_pkg::ctl_cmd_type cmd;
   rle_pkg::dp_sts_type  sts;

   rle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rle_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
